>>> design/slkt_pkg.sv
package slkt_pkg;

    // Table geometry
    localparam int MAX_ENTRIES  = 31;
    localparam int KEY_BITS     = 32;
    localparam int PAGE_BITS    = 20;
    localparam int SLOT_BITS    = 10;
    localparam int ENTRIES_BITS = 5;
    localparam int OP_BITS      = 3;
    localparam int STATUS_BITS  = 3;

    // Derived widths
    localparam int ADDR_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int ENTRY_W = KEY_BITS + PAGE_BITS + SLOT_BITS;

    // Stream payload layout
    localparam int IN_DATA_BITS  = 2 * KEY_BITS + PAGE_BITS + SLOT_BITS;
    localparam int IN_DATA_W     = ((IN_DATA_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = KEY_BITS + PAGE_BITS + SLOT_BITS + ENTRIES_BITS;
    localparam int OUT_DATA_W    = ((OUT_DATA_BITS + 7) / 8) * 8;

    // Request codes
    typedef enum logic [OP_BITS-1:0] {
        OP_INSERT        = 3'd0,
        OP_LOOKUP        = 3'd1,
        OP_REMOVE        = 3'd2,
        OP_RANGE_FROM    = 3'd3,
        OP_RANGE_BELOW   = 3'd4,
        OP_RANGE_BETWEEN = 3'd5
    } t_op;

    // Result status codes
    typedef enum logic [STATUS_BITS-1:0] {
        RS_OK        = 3'd0,
        RS_DUPLICATE = 3'd1,
        RS_NOT_FOUND = 3'd2,
        RS_FULL      = 3'd3,
        RS_EMPTY     = 3'd4
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHUP,
        S_INSWR,
        S_SHDN,
        S_RESP
    } t_state;

    // One stored record
    typedef struct packed {
        logic [KEY_BITS-1:0]  key;
        logic [PAGE_BITS-1:0] page;
        logic [SLOT_BITS-1:0] slot;
    } t_entry;

endpackage

>>> design/sorted_leaf_key_table.sv
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: key, key_end, page_in, slot_in; tuser: op
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: key_out, page_out, slot_out, entries;
//                                              tuser: status; tlast: last
//
// One request at a time; s_axis_tready is high only while out of reset and idle.
// A request walks the table one stored entry at a time through the table read port and the
// shared compare unit, plus the record shift on insert or remove, the new-entry write and
// the response.
// Range scans emit one item per match, or one empty marker when none match, and pause
// the walk at a match while the output is stalled.
// Synchronous active-low reset empties the table (fill count to zero); no clearing pass.
module sorted_leaf_key_table
    import slkt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,  // key, key_end, page_in, slot_in, zero pad
    input  logic [OP_BITS-1:0]     s_axis_tuser,  // op
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,  // key_out, page_out, slot_out, entries, pad
    output logic [STATUS_BITS-1:0] m_axis_tuser,  // status
    output logic                   m_axis_tlast   // last
);

    localparam int KE_LO   = KEY_BITS;
    localparam int PG_LO   = 2 * KEY_BITS;
    localparam int SL_LO   = 2 * KEY_BITS + PAGE_BITS;
    localparam int PAD_OUT = OUT_DATA_W - OUT_DATA_BITS;

    t_state r_state, n_state;

    // Request fields
    logic [OP_BITS-1:0]          r_op;
    logic signed [KEY_BITS-1:0]  r_key, r_key_end;
    logic [PAGE_BITS-1:0]        r_page;
    logic [SLOT_BITS-1:0]        r_slot;

    // Walk control
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [CNT_W-1:0] r_ptr, n_ptr;
    logic [CNT_W-1:0] r_pos, n_pos;
    t_entry           r_res, n_res;
    t_status          r_res_st, n_res_st;
    logic             r_pvld, n_pvld;

    // Output register
    logic                    r_ovalid;
    logic [KEY_BITS-1:0]     r_okey, n_okey;
    logic [PAGE_BITS-1:0]    r_opage, n_opage;
    logic [SLOT_BITS-1:0]    r_oslot, n_oslot;
    logic [ENTRIES_BITS-1:0] r_oent, n_oent;
    t_status                 r_ostat, n_ostat;
    logic                    r_olast, n_olast;
    logic                    ld_out;
    logic                    out_free;

    // Table port
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    t_entry             wr_data;
    logic [ENTRY_W-1:0] rd_q;
    t_entry             rd_e;

    // Shared compare unit
    logic signed [KEY_BITS-1:0] e_key;
    logic ge_k, eq_k, lt_ke, at_end, hit;
    logic [CNT_W-1:0] ptr_inc;
    logic in_acc;

    slkt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_q)
    );

    assign rd_e    = t_entry'(rd_q);
    assign e_key   = $signed(rd_e.key);
    assign ge_k    = e_key >= r_key;
    assign eq_k    = rd_e.key == r_key;
    assign lt_ke   = e_key < r_key_end;
    assign at_end  = r_ptr == r_fill;
    assign ptr_inc = r_ptr + CNT_W'(1);

    assign s_axis_tready = i_rst_n && (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ovalid || m_axis_tready;

    // Match rule of the range scans
    always_comb begin
        unique case (r_op)
            OP_RANGE_FROM:    hit = ge_k;
            OP_RANGE_BELOW:   hit = !ge_k;
            OP_RANGE_BETWEEN: hit = ge_k && lt_ke;
            default:          hit = 1'b0;
        endcase
    end

    // Sequencer: next state, table port and output load
    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_ptr    = r_ptr;
        n_pos    = r_pos;
        n_res    = r_res;
        n_res_st = r_res_st;
        n_pvld   = r_pvld;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = r_ptr[ADDR_W-1:0];
        wr_data  = rd_e;
        ld_out   = 1'b0;
        n_okey   = r_res.key;
        n_opage  = r_res.page;
        n_oslot  = r_res.slot;
        n_oent   = ENTRIES_BITS'(r_fill);
        n_ostat  = r_res_st;
        n_olast  = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_ptr  = '0;
                    n_pvld = 1'b0;
                    unique case (s_axis_tuser)
                        OP_INSERT, OP_LOOKUP, OP_REMOVE,
                        OP_RANGE_FROM, OP_RANGE_BELOW, OP_RANGE_BETWEEN: begin
                            n_state = S_SCAN;
                        end
                        default: begin
                            // Unknown request: answer not found
                            n_res.key  = s_axis_tdata[KEY_BITS-1:0];
                            n_res.page = '0;
                            n_res.slot = '0;
                            n_res_st   = RS_NOT_FOUND;
                            n_state    = S_RESP;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                rd_addr = ADDR_W'(ptr_inc);
                n_ptr   = ptr_inc;
                unique case (r_op)
                    OP_INSERT: begin
                        if (at_end || ge_k) begin
                            n_ptr = r_ptr;
                            if (!at_end && eq_k) begin
                                n_res.key  = r_key;
                                n_res.page = rd_e.page;
                                n_res.slot = rd_e.slot;
                                n_res_st   = RS_DUPLICATE;
                                n_state    = S_RESP;
                            end else if (r_fill == CNT_W'(MAX_ENTRIES)) begin
                                n_res.key  = r_key;
                                n_res.page = '0;
                                n_res.slot = '0;
                                n_res_st   = RS_FULL;
                                n_state    = S_RESP;
                            end else if (at_end) begin
                                n_pos   = r_ptr;
                                n_state = S_INSWR;
                            end else begin
                                // Open a gap: move entries up from the top
                                n_pos   = r_ptr;
                                n_ptr   = r_fill;
                                rd_addr = ADDR_W'(r_fill - CNT_W'(1));
                                n_state = S_SHUP;
                            end
                        end
                    end
                    OP_LOOKUP, OP_REMOVE: begin
                        if (at_end || ge_k) begin
                            n_ptr      = r_ptr;
                            n_res.key  = r_key;
                            n_res.page = '0;
                            n_res.slot = '0;
                            n_res_st   = RS_NOT_FOUND;
                            n_state    = S_RESP;
                            if (!at_end && eq_k) begin
                                n_res.page = rd_e.page;
                                n_res.slot = rd_e.slot;
                                n_res_st   = RS_OK;
                                if (r_op == OP_REMOVE) begin
                                    n_state = S_SHDN;
                                end
                            end
                        end
                    end
                    default: begin
                        if (at_end) begin
                            // Close the scan with the held match or an empty marker
                            n_ptr = r_ptr;
                            if (r_pvld) begin
                                n_res_st = RS_OK;
                            end else begin
                                n_res.key  = r_key;
                                n_res.page = '0;
                                n_res.slot = '0;
                                n_res_st   = RS_EMPTY;
                            end
                            n_state = S_RESP;
                        end else if (hit) begin
                            if (!r_pvld) begin
                                n_res  = rd_e;
                                n_pvld = 1'b1;
                            end else if (out_free) begin
                                // Send the held match, hold this one
                                ld_out  = 1'b1;
                                n_ostat = RS_OK;
                                n_olast = 1'b0;
                                n_res   = rd_e;
                            end else begin
                                // Output stalled: re-read the same entry
                                rd_addr = r_ptr[ADDR_W-1:0];
                                n_ptr   = r_ptr;
                            end
                        end
                    end
                endcase
            end

            S_SHUP: begin
                // Move entry ptr-1 up to ptr
                wr_en   = 1'b1;
                wr_addr = r_ptr[ADDR_W-1:0];
                rd_addr = ADDR_W'(r_ptr - CNT_W'(2));
                if (r_ptr - CNT_W'(1) == r_pos) begin
                    n_state = S_INSWR;
                end else begin
                    n_ptr = r_ptr - CNT_W'(1);
                end
            end

            S_INSWR: begin
                wr_en        = 1'b1;
                wr_addr      = r_pos[ADDR_W-1:0];
                wr_data.key  = r_key;
                wr_data.page = r_page;
                wr_data.slot = r_slot;
                n_res        = wr_data;
                n_res_st     = RS_OK;
                n_fill       = r_fill + CNT_W'(1);
                n_state      = S_RESP;
            end

            S_SHDN: begin
                // Move entry ptr+1 down to ptr
                rd_addr = ADDR_W'(r_ptr + CNT_W'(2));
                if (ptr_inc < r_fill) begin
                    wr_en   = 1'b1;
                    wr_addr = r_ptr[ADDR_W-1:0];
                    n_ptr   = ptr_inc;
                end else begin
                    n_fill  = r_fill - CNT_W'(1);
                    n_state = S_RESP;
                end
            end

            S_RESP: begin
                if (out_free) begin
                    ld_out  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_ptr    <= '0;
            r_pos    <= '0;
            r_pvld   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_ptr   <= n_ptr;
            r_pos   <= n_pos;
            r_pvld  <= n_pvld;
            if (ld_out) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_res    <= n_res;
        r_res_st <= n_res_st;
        if (in_acc) begin
            r_op      <= s_axis_tuser;
            r_key     <= s_axis_tdata[KEY_BITS-1:0];
            r_key_end <= s_axis_tdata[KE_LO +: KEY_BITS];
            r_page    <= s_axis_tdata[PG_LO +: PAGE_BITS];
            r_slot    <= s_axis_tdata[SL_LO +: SLOT_BITS];
        end
        if (ld_out) begin
            r_okey  <= n_okey;
            r_opage <= n_opage;
            r_oslot <= n_oslot;
            r_oent  <= n_oent;
            r_ostat <= n_ostat;
            r_olast <= n_olast;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{PAD_OUT{1'b0}}, r_oent, r_oslot, r_opage, r_okey};
    assign m_axis_tuser  = r_ostat;
    assign m_axis_tlast  = r_olast;

    // Fill count stays within the table
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(MAX_ENTRIES))
        else $error("fill count beyond table size");

    // Fill count moves by at most one per cycle
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_fill == $past(r_fill)) || (r_fill == $past(r_fill) + CNT_W'(1))
                    || (r_fill == $past(r_fill) - CNT_W'(1)))
        else $error("fill count jumped");

    // Only the insert write or the end of a remove changes the fill count
    a_fill_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_fill == $past(r_fill))
                    || $past(r_state == S_INSWR) || $past(r_state == S_SHDN))
        else $error("fill count changed outside insert or remove");

    // Upward shift never writes at or below the insert position
    a_shup_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHUP) |-> (r_ptr > r_pos))
        else $error("shift passed insert position");

    // Between requests only a final item can be waiting
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_ovalid) |-> r_olast)
        else $error("non-final item pending while idle");

endmodule

>>> design/slkt_ram.sv
module slkt_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one word, read one word registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> dv/sorted_leaf_key_table_tb.sv
`timescale 1ns / 1ps

module sorted_leaf_key_table_tb;
    import slkt_pkg::*;

    // Op codes outside the defined set; the block must answer them as not found
    localparam logic [OP_BITS-1:0] OP_RESERVED_6 = 3'd6;
    localparam logic [OP_BITS-1:0] OP_RESERVED_7 = 3'd7;

    localparam logic signed [KEY_BITS-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_BITS-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic [KEY_BITS-1:0]     key;
        logic [PAGE_BITS-1:0]    page;
        logic [SLOT_BITS-1:0]    slot;
        logic [ENTRIES_BITS-1:0] entries;
        t_status                 status;
        logic                    last;
    } t_table_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;   // key, key_end, page_in, slot_in, zero pad
    logic [OP_BITS-1:0]     s_axis_tuser;   // op
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;   // key_out, page_out, slot_out, entries, pad
    logic [STATUS_BITS-1:0] m_axis_tuser;   // status
    logic                   m_axis_tlast;   // last

    // Shadow copy of the sorted table
    logic signed [KEY_BITS-1:0] tbl_key  [MAX_ENTRIES];
    logic [PAGE_BITS-1:0]       tbl_page [MAX_ENTRIES];
    logic [SLOT_BITS-1:0]       tbl_slot [MAX_ENTRIES];
    int                         tbl_fill;

    t_table_result awaited_results[$];
    int            mismatches;
    bit            quiet;

    sorted_leaf_key_table i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Queue one expected item, tagged with the fill count after the request
    function automatic void note_result(input logic [KEY_BITS-1:0] key,
                                        input logic [PAGE_BITS-1:0] page,
                                        input logic [SLOT_BITS-1:0] slot,
                                        input t_status status, input logic last);
        t_table_result r;
        r.key     = key;
        r.page    = page;
        r.slot    = slot;
        r.entries = ENTRIES_BITS'(tbl_fill);
        r.status  = status;
        r.last    = last;
        awaited_results.insert(awaited_results.size(), r);
    endfunction

    function automatic bit scan_hit(input logic [OP_BITS-1:0] op,
                                    input logic signed [KEY_BITS-1:0] lo, hi, e);
        case (op)
            OP_RANGE_FROM:  return e >= lo;
            OP_RANGE_BELOW: return e < lo;
            default:        return e >= lo && e < hi;
        endcase
    endfunction

    // Apply one request to the shadow table and queue the items it yields
    function automatic void apply_request(input logic [OP_BITS-1:0] op,
                                          input logic signed [KEY_BITS-1:0] key, key_end,
                                          input logic [PAGE_BITS-1:0] page,
                                          input logic [SLOT_BITS-1:0] slot);
        int pos;
        int ins;
        int hits;
        int seen;
        pos = -1;
        for (int i = 0; i < tbl_fill; i++)
            if (tbl_key[i] == key) pos = i;
        case (op)
            OP_INSERT: begin
                if (pos >= 0) begin
                    note_result(key, tbl_page[pos], tbl_slot[pos], RS_DUPLICATE, 1'b1);
                end else if (tbl_fill >= MAX_ENTRIES) begin
                    note_result(key, '0, '0, RS_FULL, 1'b1);
                end else begin
                    ins = 0;
                    while (ins < tbl_fill && tbl_key[ins] < key) ins++;
                    for (int j = tbl_fill; j > ins; j--) begin
                        tbl_key[j]  = tbl_key[j-1];
                        tbl_page[j] = tbl_page[j-1];
                        tbl_slot[j] = tbl_slot[j-1];
                    end
                    tbl_key[ins]  = key;
                    tbl_page[ins] = page;
                    tbl_slot[ins] = slot;
                    tbl_fill++;
                    note_result(key, page, slot, RS_OK, 1'b1);
                end
            end
            OP_LOOKUP, OP_REMOVE: begin
                if (pos < 0) begin
                    note_result(key, '0, '0, RS_NOT_FOUND, 1'b1);
                end else begin
                    page = tbl_page[pos];
                    slot = tbl_slot[pos];
                    if (op == OP_REMOVE) begin
                        for (int j = pos; j + 1 < tbl_fill; j++) begin
                            tbl_key[j]  = tbl_key[j+1];
                            tbl_page[j] = tbl_page[j+1];
                            tbl_slot[j] = tbl_slot[j+1];
                        end
                        tbl_fill--;
                    end
                    note_result(key, page, slot, RS_OK, 1'b1);
                end
            end
            OP_RANGE_FROM, OP_RANGE_BELOW, OP_RANGE_BETWEEN: begin
                hits = 0;
                for (int i = 0; i < tbl_fill; i++)
                    if (scan_hit(op, key, key_end, tbl_key[i])) hits++;
                if (hits == 0) begin
                    note_result(key, '0, '0, RS_EMPTY, 1'b1);
                end else begin
                    seen = 0;
                    for (int i = 0; i < tbl_fill; i++) begin
                        if (scan_hit(op, key, key_end, tbl_key[i])) begin
                            seen++;
                            note_result(tbl_key[i], tbl_page[i], tbl_slot[i], RS_OK,
                                        seen == hits);
                        end
                    end
                end
            end
            default: note_result(key, '0, '0, RS_NOT_FOUND, 1'b1);
        endcase
    endfunction

    // Drop valid and hold off the source for a number of cycles
    task automatic idle_source(input int cycles);
        if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Hold the source until every expected item has come back
    task automatic wait_for_all_results();
        if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
    endtask

    // Offer one request, wait for the handshake, then predict and maybe pause
    task automatic send_request(input logic [OP_BITS-1:0] op,
                                input logic signed [KEY_BITS-1:0] key, key_end,
                                input logic [PAGE_BITS-1:0] page,
                                input logic [SLOT_BITS-1:0] slot);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= IN_DATA_W'({slot, page, key_end, key});
        do @(posedge i_clk); while (!s_axis_tready);
        apply_request(op, key, key_end, page, slot);
        if (!quiet && $urandom_range(0, 3) == 0) idle_source($urandom_range(1, 19));
    endtask

    // Favor keys already held so lookups, removes and duplicates hit
    function automatic logic signed [KEY_BITS-1:0] choose_key();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                if (tbl_fill > 0) return tbl_key[$urandom_range(0, tbl_fill - 1)];
                return $signed($urandom_range(0, 127)) - 64;
            end
            4, 5: return $signed($urandom_range(0, 127)) - 64;
            6, 7: return $urandom();
            8: begin
                case ($urandom_range(0, 3))
                    0:       return KEY_MIN;
                    1:       return KEY_MAX;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default: begin
                if (tbl_fill > 0)
                    return tbl_key[$urandom_range(0, tbl_fill - 1)]
                           + ($urandom_range(0, 1) ? 1 : -1);
                return $urandom();
            end
        endcase
    endfunction

    // One random request; weights for insert and remove in percent
    task automatic random_request(input int ins_pct, input int rem_pct);
        int                         pick;
        logic [OP_BITS-1:0]         op;
        logic signed [KEY_BITS-1:0] key;
        logic signed [KEY_BITS-1:0] key_end;
        logic [SLOT_BITS-1:0]       slot;
        pick = $urandom_range(0, 99);
        if (pick < ins_pct) begin
            op = OP_INSERT;
        end else if (pick < ins_pct + rem_pct) begin
            op = OP_REMOVE;
        end else begin
            case ($urandom_range(0, 15))
                0, 1, 2, 3:     op = OP_LOOKUP;
                4, 5, 6:        op = OP_RANGE_FROM;
                7, 8, 9:        op = OP_RANGE_BELOW;
                10, 11, 12, 13: op = OP_RANGE_BETWEEN;
                14:             op = OP_RESERVED_6;
                default:        op = OP_RESERVED_7;
            endcase
        end
        if (op == OP_INSERT && $urandom_range(0, 4) != 0)
            key = $urandom();
        else
            key = choose_key();
        key_end = $urandom_range(0, 1) ? key + $signed($urandom_range(0, 1 << 24))
                                       : choose_key();
        slot = $urandom_range(0, 7) == 0 ? SLOT_BITS'($urandom())
                                         : SLOT_BITS'($urandom_range(1, 512));
        send_request(op, key, key_end, PAGE_BITS'($urandom()), slot);
    endtask

    // Compare one output field against its expectation
    function automatic void check_field(input string what, input logic [KEY_BITS-1:0] want,
                                        input logic [KEY_BITS-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // Check every accepted output item against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_table_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected item: expected none, actual key %0h status %0d",
                         $time, m_axis_tdata[31:0], m_axis_tuser);
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                check_field("key_out",  want.key,     m_axis_tdata[31:0]);
                check_field("page_out", want.page,    m_axis_tdata[51:32]);
                check_field("slot_out", want.slot,    m_axis_tdata[61:52]);
                check_field("entries",  want.entries, m_axis_tdata[66:62]);
                check_field("status",   want.status,  m_axis_tuser);
                check_field("last",     want.last,    m_axis_tlast);
            end
        end
    end

    // Stall the result side in random bursts, none in the quiet tail
    initial begin
        int stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0 && !quiet) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(1, 19) - 1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic test_empty_table();
        send_request(OP_LOOKUP, 5, 0, 1, 1);
        send_request(OP_REMOVE, 5, 0, 1, 1);
        send_request(OP_RANGE_FROM, KEY_MIN, 0, 1, 1);
        send_request(OP_RANGE_BELOW, KEY_MAX, 0, 1, 1);
        send_request(OP_RANGE_BETWEEN, KEY_MIN, KEY_MAX, 1, 1);
        send_request(OP_RESERVED_6, 3, 9, 20'hFFFFF, 10'h3FF);
        send_request(OP_RESERVED_7, -3, 9, 20'h12345, 10'h155);
    endtask

    task automatic test_insert_edges();
        send_request(OP_INSERT, KEY_MIN, 0, 1, 1);
        send_request(OP_INSERT, KEY_MAX, 0, 20'hFFFFF, 512);
        send_request(OP_INSERT, 0, 0, 0, 0);
        send_request(OP_INSERT, -1, 0, 20'hFFFFF, 10'h3FF);
        send_request(OP_INSERT, 0, 0, 9, 9);
        send_request(OP_LOOKUP, KEY_MAX, 0, 0, 0);
        send_request(OP_LOOKUP, 7, 0, 0, 0);
    endtask

    task automatic test_scan_bounds();
        send_request(OP_RANGE_FROM, 0, 0, 0, 0);
        send_request(OP_RANGE_BELOW, 0, 0, 0, 0);
        send_request(OP_RANGE_BELOW, KEY_MIN, 0, 0, 0);
        send_request(OP_RANGE_BETWEEN, -1, 0, 0, 0);
        send_request(OP_RANGE_BETWEEN, 5, 5, 0, 0);
        send_request(OP_RANGE_BETWEEN, 0, -1, 0, 0);
        send_request(OP_RANGE_FROM, KEY_MAX, 0, 0, 0);
        send_request(OP_RANGE_BETWEEN, KEY_MIN, KEY_MAX, 0, 0);
    endtask

    task automatic test_remove();
        send_request(OP_REMOVE, -1, 0, 0, 0);
        send_request(OP_REMOVE, -1, 0, 0, 0);
        send_request(OP_LOOKUP, -1, 0, 0, 0);
    endtask

    // Grow the table until it is full, then a few more requests
    task automatic test_fill_random();
        int extra;
        int sent;
        extra = 0;
        sent  = 0;
        while (extra < 8 && sent < 120) begin
            random_request(80, 5);
            sent++;
            if (tbl_fill == MAX_ENTRIES) extra++;
        end
    endtask

    // Scan and insert against a full table after letting the block drain
    task automatic test_full_table();
        wait_for_all_results();
        send_request(OP_RANGE_FROM, KEY_MIN, 0, 0, 0);
        send_request(OP_RANGE_BELOW, KEY_MAX, 0, 0, 0);
        send_request(OP_RANGE_BETWEEN, tbl_key[tbl_fill / 4], tbl_key[(3 * tbl_fill) / 4],
                     0, 0);
        send_request(OP_INSERT, $urandom(), 0, 20'h5A5A5, 10'h2A5);
        send_request(OP_INSERT, tbl_key[tbl_fill - 1], 0, 20'h1, 10'h1);
    endtask

    task automatic test_mixed_random();
        repeat (10) random_request(30, 20);
    endtask

    // Remove-heavy random traffic; the tail runs with no idling on either side
    task automatic test_drain_random();
        for (int n = 0; n < 20; n++) begin
            if (n == 10) quiet = 1'b1;
            random_request(10, 55);
        end
    endtask

    initial begin
        quiet       = 1'b0;
        mismatches  = 0;
        tbl_fill    = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_insert_edges();
        test_scan_bounds();
        test_remove();
        test_fill_random();
        test_full_table();
        test_mixed_random();
        test_drain_random();

        // Let the last items out, then watch for strays
        if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (MAX_ENTRIES + 8) @(posedge i_clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sim.f
design/slkt_pkg.sv
design/slkt_ram.sv
design/sorted_leaf_key_table.sv
dv/sorted_leaf_key_table_tb.sv
